// ===== src/mcod_pkg.sv =====
// package: types and constants for the matrix chain order block
`timescale 1ns / 1ps
package mcod_pkg;
    localparam int MAX_MATRICES = 16;
    localparam int DIM_BITS     = 12;
    localparam int SIDE         = MAX_MATRICES + 1;
    localparam int IDX_BITS     = $clog2(SIDE);
    localparam int CNT_BITS     = $clog2(MAX_MATRICES + 1);
    localparam int ADDR_BITS    = $clog2(SIDE * SIDE);
    localparam int COST_BITS    = 40;
    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    typedef struct packed {
        logic [11:0] rows;
        logic [11:0] cols;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [3:0]           lo;
        logic [4:0]           hi;
        logic [3:0]           split;
        logic                 is_leaf;
        logic [COST_BITS-1:0] cost;
        logic                 last_node;
    } t_out;

    function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                     input logic [COST_BITS-1:0] b);
        logic [COST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
    endfunction
endpackage

// ===== src/mcod_mul3.sv =====
// product of three dimensions: a*b and c registered, then multiplied
`timescale 1ns / 1ps
module mcod_mul3
    import mcod_pkg::*;
(
    input  logic                  i_clk,
    input  logic [DIM_BITS-1:0]   i_a,
    input  logic [DIM_BITS-1:0]   i_b,
    input  logic [DIM_BITS-1:0]   i_c,
    output logic [COST_BITS-1:0]  o_p
);
    logic [2*DIM_BITS-1:0] r_ab;
    logic [DIM_BITS-1:0]   r_c;
    logic [3*DIM_BITS-1:0] w_p;

    always_ff @(posedge i_clk) begin
        r_ab <= i_a * i_b;
        r_c  <= i_c;
    end

    assign w_p = r_ab * r_c;
    // product width stays below the cost field, no clipping needed
    assign o_p = COST_BITS'(w_p);
endmodule

// ===== src/matrix_chain_order_dp.sv =====
// top level: matrix chain order by bottom-up table fill and preorder walk
`timescale 1ns / 1ps
// One item per matrix enters on i_start while o_busy is low; each of the
// first 16 items stores rows/cols into the dimension registers, and later
// items store nothing. The item with last set starts the work and o_busy
// stays high until the walk is done.
// The fill runs one candidate split at a time through a shared unit: two
// reads through the single read port of the cost memory, a pipelined
// three-way product and a compare (S_RDA, S_RDB, S_WAITB, S_CMP), then one
// write (S_WR) per interval. The walk then reads the cost and split memories
// once per tree node, giving 2n-1 results, one per pass through S_POP,
// S_WRD, S_EMIT and S_DONE, each shown for one cycle on o_result with
// o_valid. The final one carries last_node. Reset clears the count and the
// control; the tables need no clearing since only written entries are read.
// The receiver cannot stall; every strobed result is a transfer.
module matrix_chain_order_dp
    import mcod_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_item,
    output logic o_busy,
    output logic o_valid,
    output t_out o_result
);
    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_INIT  = 11'b00000000010,
        S_RDA   = 11'b00000000100,
        S_RDB   = 11'b00000001000,
        S_WAITB = 11'b00000010000,
        S_CMP   = 11'b00000100000,
        S_WR    = 11'b00001000000,
        S_POP   = 11'b00010000000,
        S_WRD   = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [DIM_BITS-1:0] r_dims [SIDE];
    logic [CNT_BITS-1:0] r_count;
    logic [IDX_BITS-1:0] r_len, r_lo, r_k, r_best_k;
    logic [COST_BITS-1:0] r_best, r_ca;
    logic                r_have;

    logic [COST_BITS-1:0] mem_cost [SIDE*SIDE];
    logic [IDX_BITS-1:0]  mem_split [SIDE*SIDE];
    logic [COST_BITS-1:0] r_rd_cost;
    logic [IDX_BITS-1:0]  r_rd_split;
    logic [ADDR_BITS-1:0] w_raddr, w_waddr;
    logic                 w_we;
    logic [COST_BITS-1:0] w_wcost;
    logic [IDX_BITS-1:0]  w_wsplit;

    logic [IDX_BITS-1:0] r_stk_lo [SIDE];
    logic [IDX_BITS-1:0] r_stk_hi [SIDE];
    logic [IDX_BITS:0]   r_sp;
    logic [IDX_BITS-1:0] r_nlo, r_nhi;

    logic [IDX_BITS-1:0] w_hi;
    logic [COST_BITS-1:0] w_p, w_cand;
    logic                 w_accept;

    function automatic logic [ADDR_BITS-1:0] addr(input logic [IDX_BITS-1:0] a,
                                                   input logic [IDX_BITS-1:0] b);
        return ADDR_BITS'(a * SIDE + b);
    endfunction

    assign w_accept = i_start && !o_busy;
    assign o_busy   = (r_state != S_LOAD);
    assign w_hi     = r_lo + r_len;

    mcod_mul3 u_mul (
        .i_clk (i_clk),
        .i_a   (r_dims[r_lo]),
        .i_b   (r_dims[r_k]),
        .i_c   (r_dims[w_hi]),
        .o_p   (w_p)
    );

    assign w_cand = sat_add(sat_add(r_ca, r_rd_cost), w_p);

    always_comb begin
        w_raddr = addr(r_lo, r_k);
        case (r_state)
            // hold the second operand address so it is still there at the compare
            S_RDB, S_WAITB: w_raddr = addr(r_k, w_hi);
            S_POP:   w_raddr = addr(r_stk_lo[r_sp[IDX_BITS-1:0] - 1'b1],
                                    r_stk_hi[r_sp[IDX_BITS-1:0] - 1'b1]);
            S_WRD:   w_raddr = addr(r_nlo, r_nhi);
            default: w_raddr = addr(r_lo, r_k);
        endcase
    end

    always_comb begin
        w_we     = 1'b0;
        w_waddr  = addr(r_lo, w_hi);
        w_wcost  = r_best;
        w_wsplit = r_best_k;
        case (r_state)
            S_INIT: begin
                w_we     = 1'b1;
                w_waddr  = addr(r_lo, r_lo + 1'b1);
                w_wcost  = '0;
                w_wsplit = '0;
            end
            S_WR:    w_we = 1'b1;
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_cost[w_waddr]  <= w_wcost;
            mem_split[w_waddr] <= w_wsplit;
        end
        r_rd_cost  <= mem_cost[w_raddr];
        r_rd_split <= mem_split[w_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:  if (w_accept && i_item.last) n_state = S_INIT;
            S_INIT:  if (r_lo == IDX_BITS'(r_count - 1'b1))
                         n_state = (r_count > 1) ? S_RDA : S_POP;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_WAITB;
            S_WAITB: n_state = S_CMP;
            S_CMP:   n_state = (r_k == w_hi - 1'b1) ? S_WR : S_RDA;
            S_WR: begin
                if (w_hi == IDX_BITS'(r_count))
                    n_state = (r_len == IDX_BITS'(r_count)) ? S_POP : S_RDA;
                else
                    n_state = S_RDA;
            end
            S_POP:   n_state = S_WRD;
            S_WRD:   n_state = S_EMIT;
            S_EMIT:  n_state = S_DONE;
            S_DONE:  n_state = (r_sp == 0) ? S_LOAD : S_POP;
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_sp    <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            case (r_state)
                S_LOAD: if (w_accept) begin
                    if (r_count < CNT_BITS'(MAX_MATRICES)) begin
                        r_dims[r_count[IDX_BITS-1:0]]        <= i_item.rows[DIM_BITS-1:0];
                        r_dims[r_count[IDX_BITS-1:0] + 1'b1] <= i_item.cols[DIM_BITS-1:0];
                        r_count <= r_count + 1'b1;
                    end
                    r_lo <= '0;
                    // push the whole chain as the root of the walk
                    r_stk_lo[0] <= '0;
                    r_stk_hi[0] <= (r_count < CNT_BITS'(MAX_MATRICES))
                                   ? IDX_BITS'(r_count + 1'b1) : IDX_BITS'(r_count);
                    r_sp   <= (IDX_BITS+1)'(1);
                end
                S_INIT: begin
                    r_lo   <= r_lo + 1'b1;
                    r_len  <= IDX_BITS'(2);
                    r_k    <= IDX_BITS'(1);
                    r_have <= 1'b0;
                    if (r_lo == IDX_BITS'(r_count - 1'b1)) r_lo <= '0;
                end
                S_RDB:   r_ca <= r_rd_cost;
                S_CMP: begin
                    if (!r_have || w_cand < r_best) begin
                        r_best   <= w_cand;
                        r_best_k <= r_k;
                    end
                    r_have <= 1'b1;
                    r_k    <= r_k + 1'b1;
                end
                S_WR: begin
                    r_have <= 1'b0;
                    if (w_hi == IDX_BITS'(r_count)) begin
                        r_lo  <= '0;
                        r_len <= r_len + 1'b1;
                        r_k   <= IDX_BITS'(1);
                    end else begin
                        r_lo <= r_lo + 1'b1;
                        r_k  <= r_lo + 2'd2;
                    end
                end
                S_POP: begin
                    r_nlo <= r_stk_lo[r_sp[IDX_BITS-1:0] - 1'b1];
                    r_nhi <= r_stk_hi[r_sp[IDX_BITS-1:0] - 1'b1];
                    r_sp  <= r_sp - 1'b1;
                end
                S_WRD: ;
                S_EMIT: begin
                    o_valid          <= 1'b1;
                    o_result.lo      <= 4'(r_nlo);
                    o_result.hi      <= 5'(r_nhi);
                    if (r_nlo + 1'b1 >= r_nhi) begin
                        o_result.split   <= '0;
                        o_result.is_leaf <= 1'b1;
                        o_result.cost    <= '0;
                        o_result.last_node <= (r_sp == 0);
                    end else begin
                        o_result.split   <= 4'(r_rd_split);
                        o_result.is_leaf <= 1'b0;
                        o_result.cost    <= r_rd_cost;
                        o_result.last_node <= 1'b0;
                        r_stk_lo[r_sp[IDX_BITS-1:0]]        <= r_rd_split;
                        r_stk_hi[r_sp[IDX_BITS-1:0]]        <= r_nhi;
                        r_stk_lo[r_sp[IDX_BITS-1:0] + 1'b1] <= r_nlo;
                        r_stk_hi[r_sp[IDX_BITS-1:0] + 1'b1] <= r_rd_split;
                        r_sp <= r_sp + 2'd2;
                    end
                end
                S_DONE: if (r_sp == 0) r_count <= '0;
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_EMIT)
        else $error("result strobe outside emit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_node) |=> r_state == S_LOAD && r_count == 0)
        else $error("walk did not end on last node");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_MATRICES))
        else $error("matrix count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= (IDX_BITS+1)'(SIDE))
        else $error("walk stack overflow");
endmodule

// ===== sim/mcod_checker.sv =====
// checker: predicts the preorder node stream of each chain and compares it
`timescale 1ns / 1ps
module mcod_checker
    import mcod_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_item,
    input  logic i_busy,
    input  logic i_valid,
    input  t_out i_result,
    output int   o_errors,
    output int   o_pending,
    output int   o_nodes_seen
);
    logic [DIM_BITS-1:0]  chain_dims [SIDE];
    int                   chain_len;
    logic [COST_BITS-1:0] best_cost  [SIDE][SIDE];
    int                   best_split [SIDE][SIDE];
    t_out                 node_queue [$];

    function automatic logic [COST_BITS-1:0] sat_sum(logic [COST_BITS-1:0] a,
                                                     logic [COST_BITS-1:0] b);
        logic [COST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
    endfunction

    function automatic logic [COST_BITS-1:0] sat_prod(int i, int k, int j);
        logic [63:0] p;
        p = 64'(chain_dims[i]) * 64'(chain_dims[k]) * 64'(chain_dims[j]);
        return (p > 64'(COST_MAX)) ? COST_MAX : p[COST_BITS-1:0];
    endfunction

    task automatic predict_chain(int n);
        logic [COST_BITS-1:0] r;
        int   st_lo [$];
        int   st_hi [$];
        int   lo, hi, s;
        t_out nd;
        for (int a = 0; a < n; a++) best_cost[a][a+1] = '0;
        for (int len = 2; len <= n; len++) begin
            for (int a = 0; a + len <= n; a++) begin
                best_split[a][a+len] = -1;
                for (int k = a + 1; k < a + len; k++) begin
                    r = sat_sum(sat_sum(best_cost[a][k], best_cost[k][a+len]),
                                sat_prod(a, k, a + len));
                    if (best_split[a][a+len] < 0 || r < best_cost[a][a+len]) begin
                        best_cost[a][a+len]  = r;
                        best_split[a][a+len] = k;
                    end
                end
            end
        end
        st_lo.push_back(0);
        st_hi.push_back(n);
        while (st_lo.size() > 0) begin
            lo = st_lo.pop_back();
            hi = st_hi.pop_back();
            nd = '0;
            nd.lo = 4'(lo);
            nd.hi = 5'(hi);
            if (lo + 1 >= hi) begin
                nd.is_leaf = 1'b1;
            end else begin
                s = best_split[lo][hi];
                nd.split = 4'(s);
                nd.cost  = best_cost[lo][hi];
                st_lo.push_back(s);  st_hi.push_back(hi);
                st_lo.push_back(lo); st_hi.push_back(s);
            end
            if (st_lo.size() == 0) nd.last_node = 1'b1;
            node_queue.push_back(nd);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            chain_len = 0;
            o_errors     <= 0;
            o_nodes_seen <= 0;
        end else begin
            if (i_valid) begin
                if (node_queue.size() == 0) begin
                    $error("node with nothing expected: lo=%0d hi=%0d",
                           i_result.lo, i_result.hi);
                    o_errors <= o_errors + 1;
                end else begin
                    want = node_queue.pop_front();
                    if (i_result !== want) begin
                        o_errors <= o_errors + 1;
                        if (i_result.lo !== want.lo)
                            $error("lo: expected %0d got %0d", want.lo, i_result.lo);
                        if (i_result.hi !== want.hi)
                            $error("hi: expected %0d got %0d", want.hi, i_result.hi);
                        if (i_result.split !== want.split)
                            $error("split: expected %0d got %0d", want.split,
                                   i_result.split);
                        if (i_result.is_leaf !== want.is_leaf)
                            $error("is_leaf: expected %0d got %0d", want.is_leaf,
                                   i_result.is_leaf);
                        if (i_result.cost !== want.cost)
                            $error("cost: expected %0d got %0d", want.cost,
                                   i_result.cost);
                        if (i_result.last_node !== want.last_node)
                            $error("last_node: expected %0d got %0d",
                                   want.last_node, i_result.last_node);
                    end
                end
                o_nodes_seen <= o_nodes_seen + 1;
            end
            if (i_start && !i_busy) begin
                if (chain_len < MAX_MATRICES) begin
                    chain_dims[chain_len]     = i_item.rows[DIM_BITS-1:0];
                    chain_dims[chain_len + 1] = i_item.cols[DIM_BITS-1:0];
                    chain_len++;
                end
                if (i_item.last) begin
                    predict_chain(chain_len);
                    chain_len = 0;
                end
            end
        end
        o_pending <= node_queue.size();
    end
endmodule

// ===== sim/tb_matrix_chain_order_dp.sv =====
// testbench top: chain stimulus, clock, reset, watchdog and verdict
`timescale 1ns / 1ps
module tb_matrix_chain_order_dp
    import mcod_pkg::*;
();

    localparam int WATCHDOG = 400000;

    logic i_clk, i_rst_n, i_start;
    t_in  i_item;
    logic o_busy, o_valid;
    t_out o_result;
    int   errors, pending, nodes_seen, idle_cycles, items_sent, chains_sent;
    int   burst_left;

    matrix_chain_order_dp u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .o_busy(o_busy), .o_valid(o_valid), .o_result(o_result)
    );

    mcod_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .i_busy(o_busy), .i_valid(o_valid), .i_result(o_result),
        .o_errors(errors), .o_pending(pending), .o_nodes_seen(nodes_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one matrix transfer, with gaps between bursts
    task automatic send_item(logic [11:0] r, logic [11:0] c, logic lst);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6))
                @(negedge i_clk);
        end
        burst_left--;
        i_start = 1'b1;
        i_item  = '{rows: r, cols: c, last: lst};
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
        i_start = 1'b0;
        items_sent++;
        if (lst) chains_sent++;
    endtask

    function automatic logic [11:0] rand_dim(int mode);
        case (mode)
            0:       return 12'($urandom_range(0, 15));
            1:       return 12'($urandom_range(4000, 4095));
            default: return 12'($urandom);
        endcase
    endfunction

    // a mostly well-formed chain: each cols equals the next rows, bar random rows one time in ten
    task automatic send_chain(int n, int mode);
        logic [11:0] d;
        d = rand_dim(mode);
        for (int i = 0; i < n; i++) begin
            logic [11:0] nx;
            nx = rand_dim(mode);
            send_item(($urandom_range(0, 9) == 0) ? rand_dim(mode) : d, nx, i == n - 1);
            d = nx;
        end
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0; i_start = 1'b0; i_item = '0;
        items_sent = 0; chains_sent = 0; burst_left = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single matrix, zeros, maxima, ties, large products, overlong
        send_item(12'd0, 12'd0, 1'b1);
        send_item(12'hfff, 12'hfff, 1'b1);
        send_item(12'd5, 12'd5, 1'b0);
        send_item(12'd5, 12'd5, 1'b0);
        send_item(12'd5, 12'd5, 1'b1);
        for (int i = 0; i < 4; i++) send_item(12'hfff, 12'hfff, i == 3);
        send_item(12'd10, 12'd20, 1'b0);
        send_item(12'd30, 12'd5, 1'b1);
        for (int i = 0; i < 18; i++)
            send_item(12'(i * 241), 12'hfff - 12'(i), i == 17);
        wait (pending == 0);
        repeat (20) @(negedge i_clk);

        while (items_sent < 320) begin
            case ($urandom_range(0, 9))
                0:       n = 16;
                1:       n = $urandom_range(17, 19);
                default: n = $urandom_range(1, 6);
            endcase
            send_chain(n, $urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0) begin
                wait (pending == 0);
                @(negedge i_clk);
            end
        end

        wait (pending == 0);
        repeat (200) @(negedge i_clk);
        $display("sent %0d matrices in %0d chains, checked %0d tree nodes",
                 items_sent, chains_sent, nodes_seen);
        if (errors == 0 && pending == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
